[hw/rtl/lprl_pkg.sv]
// Shared types, constants and helpers for the longest-prefix route lookup.
// Holds the request and response payload structs, the table port structs
// and the leading-ones function. No dependencies.
package lprl_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int IDX_W  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int SLOT_W = 4;
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [ADDR_W-1:0] MASK_TOP_BIT = 32'h8000_0000;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] entry_slot;
    logic [ADDR_W-1:0] entry_dest;
    logic [ADDR_W-1:0] entry_mask;
    logic              entry_enable;
    logic [ADDR_W-1:0] lookup_addr;
  } lprl_req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] route_slot;
    logic [LEN_W-1:0]  prefix_len;
  } lprl_rsp_t;

  // Write port of the route table.
  typedef struct packed {
    logic              en;
    idx_t              idx;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic              enable;
  } lprl_wr_t;

  // One entry as read back from the route table.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
  } lprl_entry_t;

  // Count of leading one bits, found by halving the search window so the
  // path stays six steps deep instead of a 32-bit ripple.
  function automatic logic [LEN_W-1:0] leading_ones(input logic [ADDR_W-1:0] mask);
    logic [ADDR_W-1:0] v;
    logic [LEN_W-1:0]  n;
    v = mask;
    n = '0;
    if (v[31:16] == 16'hFFFF) begin
      n = n + 6'd16;
      v = v << 16;
    end
    if (v[31:24] == 8'hFF) begin
      n = n + 6'd8;
      v = v << 8;
    end
    if (v[31:28] == 4'hF) begin
      n = n + 6'd4;
      v = v << 4;
    end
    if (v[31:30] == 2'b11) begin
      n = n + 6'd2;
      v = v << 2;
    end
    if (v[31]) begin
      n = n + 6'd1;
      v = v << 1;
    end
    if ((v & MASK_TOP_BIT) != '0) begin
      n = n + 6'd1;
    end
    return n;
  endfunction

endpackage

[hw/rtl/longest_prefix_route_lookup.sv]
// Longest-prefix route lookup over a table of IPv4 routes.
// Depends on lprl_pkg and lprl_table.
//
// Requests arrive on req/req_valid/req_ready. A write request (cmd = write)
// loads destination, mask and valid mark into one slot in the cycle it is
// accepted and gives no response; the next request is taken in the next
// cycle. A lookup request scans the table one entry per cycle through the
// single read port of the table memory, followed by a match stage and a
// best-so-far stage. Its response appears on rsp/rsp_valid once the last
// entry has passed the read, match and best-so-far registers and the finish
// step, and the next request is taken after that hand-off.
// Only one request is in progress at a time, so a lookup never overlaps a
// table write.
// The response sits in an output register. While it waits for rsp_ready,
// further requests are still accepted and a new lookup scans; only its
// final hand-off waits until the register is free.
// Reset (rst, synchronous) clears all valid marks, so every lookup misses
// until routes are written, and drops any pending response.
module longest_prefix_route_lookup (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  lprl_pkg::lprl_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output lprl_pkg::lprl_rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;

  lprl_pkg::lprl_wr_t    wr;
  lprl_pkg::lprl_entry_t rd;
  logic                  rd_en;
  logic                  req_fire;
  logic                  scan_last;

  lprl_pkg::idx_t                scan_idx;
  logic [lprl_pkg::ADDR_W-1:0]   addr;

  // Read stage alignment.
  logic                          rd_vld;
  logic                          rd_last;
  lprl_pkg::idx_t                rd_idx_q;

  // Match stage.
  logic                          cand_vld;
  logic                          cand_last;
  logic                          cand_match;
  logic [lprl_pkg::LEN_W-1:0]    cand_len;
  lprl_pkg::idx_t                cand_idx;

  // Best entry so far.
  logic                          found;
  logic [lprl_pkg::LEN_W-1:0]    best_len;
  lprl_pkg::idx_t                best_idx;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign rd_en     = (state == S_SCAN);
  assign scan_last = (scan_idx == lprl_pkg::idx_t'(lprl_pkg::ROUTE_ENTRIES - 1));

  assign wr.en     = req_fire && (req.cmd == lprl_pkg::CMD_WRITE) &&
                     ({28'd0, req.entry_slot} < 32'(lprl_pkg::ROUTE_ENTRIES));
  assign wr.idx    = lprl_pkg::idx_t'(req.entry_slot);
  assign wr.dest   = req.entry_dest;
  assign wr.mask   = req.entry_mask;
  assign wr.enable = req.entry_enable;

  lprl_table u_table (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_en  (rd_en),
    .rd_idx (scan_idx),
    .rd     (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      cand_vld  <= 1'b0;
      cand_last <= 1'b0;
      found     <= 1'b0;
    end else begin
      rd_vld   <= rd_en;
      rd_last  <= rd_en && scan_last;
      rd_idx_q <= scan_idx;

      cand_vld   <= rd_vld;
      cand_last  <= rd_vld && rd_last;
      cand_match <= rd.valid && (((addr ^ rd.dest) & rd.mask) == '0);
      cand_len   <= lprl_pkg::leading_ones(rd.mask);
      cand_idx   <= rd_idx_q;

      // The first match is taken whatever its length; later ones must be
      // strictly longer, so ties keep the lowest index.
      if (cand_vld && cand_match && (!found || (cand_len > best_len))) begin
        found    <= 1'b1;
        best_len <= cand_len;
        best_idx <= cand_idx;
      end

      if (rsp_valid && rsp_ready && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire && (req.cmd == lprl_pkg::CMD_LOOKUP)) begin
            addr     <= req.lookup_addr;
            scan_idx <= '0;
            found    <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (cand_vld && cand_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            rsp.hit        <= found;
            rsp.route_slot <= found ? lprl_pkg::SLOT_W'(best_idx) : '0;
            rsp.prefix_len <= found ? best_len : '0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.hit) |-> (rsp.route_slot == '0 && rsp.prefix_len == '0))
    else $error("miss response carries a nonzero slot or length");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_FINISH))
    else $error("response raised outside the finish step");

  a_cand_in_scan: assert property (@(posedge clk) disable iff (rst)
    cand_vld |-> (state == S_SCAN || state == S_DRAIN))
    else $error("match stage active outside a scan");

  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> (!rd_vld && !cand_vld))
    else $error("pipeline not empty at finish");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.prefix_len <= lprl_pkg::LEN_W'(lprl_pkg::ADDR_W)))
    else $error("prefix length beyond address width");

endmodule

[hw/rtl/lprl_table.sv]
// Route table storage: destination and mask in a synchronous memory with a
// registered read port, valid marks in flip-flops cleared at reset.
// Depends on lprl_pkg.
module lprl_table (
  input  logic                  clk,
  input  logic                  rst,
  input  lprl_pkg::lprl_wr_t    wr,
  input  logic                  rd_en,
  input  lprl_pkg::idx_t        rd_idx,
  output lprl_pkg::lprl_entry_t rd
);

  logic [2*lprl_pkg::ADDR_W-1:0] mem [lprl_pkg::ROUTE_ENTRIES];
  logic [lprl_pkg::ROUTE_ENTRIES-1:0] valid_bits;
  logic [2*lprl_pkg::ADDR_W-1:0] rd_data;
  logic                          rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= {wr.dest, wr.mask};
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_bits[wr.idx] <= wr.enable;
      end
      if (rd_en) begin
        rd_valid <= valid_bits[rd_idx];
      end
    end
  end

  assign rd.valid = rd_valid;
  assign rd.dest  = rd_data[2*lprl_pkg::ADDR_W-1:lprl_pkg::ADDR_W];
  assign rd.mask  = rd_data[lprl_pkg::ADDR_W-1:0];

endmodule
